/* src/assert_macros.svh */
// assertion macros used by the responder core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define DNSR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every clock edge, reset included
`define DNSR_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* src/dnsr_pkg.sv */
// shared types, constants and answer-record helper for the dns responder
package dnsr_pkg;

   localparam int MAX_PACKET = 512;
   localparam int NAME_LIMIT = 256;

   localparam int POS_W    = $clog2(MAX_PACKET) + 1;
   localparam int NLEN_W   = $clog2(NAME_LIMIT);
   localparam int SUM_W    = ((NLEN_W > 8) ? NLEN_W : 8) + 1;
   localparam int ANS_LEN  = 16;
   localparam int ANS_IDX_W = $clog2(ANS_LEN);
   localparam int CSR_IDX_W = 1;
   localparam int CSR_W    = 32;

   // header offsets that get rewritten or checked, and the send length bound
   localparam logic [POS_W-1:0] POS_FLAGS_HI = POS_W'(2);
   localparam logic [POS_W-1:0] POS_FLAGS_LO = POS_W'(3);
   localparam logic [POS_W-1:0] POS_ANCNT_HI = POS_W'(6);
   localparam logic [POS_W-1:0] POS_ANCNT_LO = POS_W'(7);
   localparam logic [POS_W-1:0] POS_HDR_LAST = POS_W'(11);
   localparam logic [POS_W-1:0] POS_SEND_MAX = POS_W'(MAX_PACKET - ANS_LEN);

   localparam logic [15:0] RSP_FLAGS   = 16'h8180;
   localparam logic [15:0] RSP_ANCOUNT = 16'h0001;
   localparam logic [15:0] ANS_NAME_PTR = 16'hC00C;
   localparam logic [15:0] TYPE_A      = 16'h0001;
   localparam logic [15:0] CLASS_IN    = 16'h0001;
   localparam logic [15:0] RDLEN_A     = 16'h0004;
   localparam logic [31:0] QUESTION_OK = {TYPE_A, CLASS_IN};

   localparam logic [CSR_W-1:0] ADDRESS_RESET = 32'hC0A8_0401;
   localparam logic [CSR_W-1:0] TTL_RESET     = 32'd60;

   localparam logic [CSR_IDX_W-1:0] CSR_ANSWER_ADDRESS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ANSWER_TTL     = 1'b1;

   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_LABLEN = 3'd1,
      PH_LABEL  = 3'd2,
      PH_PTRLO  = 3'd3,
      PH_QUEST  = 3'd4,
      PH_DONE   = 3'd5,
      PH_BAD    = 3'd6
   } phase_type;

   typedef struct packed {
      logic [7:0] echo_byte;
      logic       send_ok;
   } parse_result_type;

   function automatic logic [7:0] answer_byte(input logic [ANS_IDX_W-1:0] idx,
                                              input logic [CSR_W-1:0] ttl,
                                              input logic [CSR_W-1:0] addr);
      logic [7:0] b;
      unique case (idx)
         4'd0:  b = ANS_NAME_PTR[15:8];
         4'd1:  b = ANS_NAME_PTR[7:0];
         4'd2:  b = TYPE_A[15:8];
         4'd3:  b = TYPE_A[7:0];
         4'd4:  b = CLASS_IN[15:8];
         4'd5:  b = CLASS_IN[7:0];
         4'd6:  b = ttl[31:24];
         4'd7:  b = ttl[23:16];
         4'd8:  b = ttl[15:8];
         4'd9:  b = ttl[7:0];
         4'd10: b = RDLEN_A[15:8];
         4'd11: b = RDLEN_A[7:0];
         4'd12: b = addr[31:24];
         4'd13: b = addr[23:16];
         4'd14: b = addr[15:8];
         4'd15: b = addr[7:0];
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

/* src/dnsr_parse.sv */
// per-byte header rewrite and question parser with send verdict
module dnsr_parse (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        byte_fire,
   input  logic [7:0]                  data_byte,
   input  logic                        frame_end,
   output dnsr_pkg::parse_result_type  result
);
   import dnsr_pkg::*;

   logic [POS_W-1:0]  pos_ff, pos_in;
   phase_type         phase_ff, phase_in;
   logic [7:0]        lrem_ff, lrem_in;
   logic [NLEN_W-1:0] nlen_ff, nlen_in;
   logic [31:0]       qwords_ff, qwords_in;
   logic [2:0]        qcnt_ff, qcnt_in;
   logic              reject_ff, reject_in;
   logic [SUM_W-1:0]  name_sum;
   logic [2:0]        qcnt_inc;

   assign name_sum = SUM_W'(nlen_ff) + SUM_W'(data_byte) + SUM_W'(1);
   assign qcnt_inc = qcnt_ff + 3'd1;

   always_comb begin
      pos_in    = (pos_ff == {POS_W{1'b1}}) ? pos_ff : pos_ff + POS_W'(1);
      phase_in  = phase_ff;
      lrem_in   = lrem_ff;
      nlen_in   = nlen_ff;
      qwords_in = qwords_ff;
      qcnt_in   = qcnt_ff;
      reject_in = reject_ff;
      unique case (phase_ff)
         PH_HEADER: begin
            // response bit already set in the query
            if (pos_ff == POS_FLAGS_HI && data_byte[7]) reject_in = 1'b1;
            if (pos_ff == POS_HDR_LAST) phase_in = PH_LABLEN;
         end
         PH_LABLEN: begin
            priority if (data_byte == 8'h00) begin
               phase_in = PH_QUEST;
            end else if (data_byte[7:6] == 2'b11) begin
               phase_in = PH_PTRLO;
            end else if (name_sum >= SUM_W'(NAME_LIMIT)) begin
               reject_in = 1'b1;
               phase_in  = PH_BAD;
            end else begin
               nlen_in  = name_sum[NLEN_W-1:0];
               lrem_in  = data_byte;
               phase_in = PH_LABEL;
            end
         end
         PH_LABEL: begin
            lrem_in = lrem_ff - 8'd1;
            if (lrem_in == 8'd0) phase_in = PH_LABLEN;
         end
         PH_PTRLO: phase_in = PH_QUEST;
         PH_QUEST: begin
            qwords_in = {qwords_ff[23:0], data_byte};
            qcnt_in   = qcnt_inc;
            if (qcnt_inc >= 3'd4) phase_in = PH_DONE;
         end
         PH_DONE, PH_BAD: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      unique case (pos_ff)
         POS_FLAGS_HI: result.echo_byte = RSP_FLAGS[15:8];
         POS_FLAGS_LO: result.echo_byte = RSP_FLAGS[7:0];
         POS_ANCNT_HI: result.echo_byte = RSP_ANCOUNT[15:8];
         POS_ANCNT_LO: result.echo_byte = RSP_ANCOUNT[7:0];
         default:      result.echo_byte = data_byte;
      endcase
      result.send_ok = !reject_in && phase_in == PH_DONE &&
                       qwords_in == QUESTION_OK && pos_in <= POS_SEND_MAX;
   end

   always_ff @(posedge clock) begin
      if (reset || (byte_fire && frame_end)) begin
         pos_ff    <= '0;
         phase_ff  <= PH_HEADER;
         lrem_ff   <= '0;
         nlen_ff   <= '0;
         qwords_ff <= '0;
         qcnt_ff   <= '0;
         reject_ff <= 1'b0;
      end else if (byte_fire) begin
         pos_ff    <= pos_in;
         phase_ff  <= phase_in;
         lrem_ff   <= lrem_in;
         nlen_ff   <= nlen_in;
         qwords_ff <= qwords_in;
         qcnt_ff   <= qcnt_in;
         reject_ff <= reject_in;
      end
   end

endmodule

/* src/dns_a_query_fixed_responder_core.sv */
// dns a-query responder top level: csr, output register and answer append
// a query byte is registered and appears at rsp in the cycle after its transaction
// throughput: one byte per cycle while rsp_ready is high; the byte marked frame_end adds
//   16 answer bytes, during which req_ready is low for 16 output transactions
// reset: synchronous, clears parser and output state; address 192.168.4.1, ttl 60
module dns_a_query_fixed_responder_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [7:0]                     req_data_byte,
   input  logic                           req_frame_end,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [7:0]                     rsp_out_byte,
   output logic                           rsp_out_end,
   output logic                           rsp_send_frame,
   input  logic                           csr_write_en,
   input  logic [dnsr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dnsr_pkg::CSR_W-1:0]     csr_wdata
);
   import dnsr_pkg::*;
   `include "assert_macros.svh"

   logic [CSR_W-1:0]     addr_ff, ttl_ff;
   logic                 valid_ff, valid_in;
   logic [7:0]           byte_ff, byte_in;
   logic                 end_ff, end_in;
   logic                 send_ff, send_in;
   logic                 append_ff, append_in;
   logic [ANS_IDX_W-1:0] idx_ff, idx_in;
   logic                 verdict_ff, verdict_in;
   logic                 out_load;
   logic                 req_fire;
   logic                 req_fire_last;
   parse_result_type     parse_res;

   assign out_load      = !valid_ff || rsp_ready;
   assign req_ready     = out_load && !append_ff;
   assign req_fire      = req_valid && req_ready;
   assign req_fire_last = req_fire && req_frame_end;

   dnsr_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .byte_fire (req_fire),
      .data_byte (req_data_byte),
      .frame_end (req_frame_end),
      .result    (parse_res)
   );

   always_comb begin
      valid_in   = valid_ff;
      byte_in    = byte_ff;
      end_in     = end_ff;
      send_in    = send_ff;
      append_in  = append_ff;
      idx_in     = idx_ff;
      verdict_in = verdict_ff;
      if (out_load) begin
         priority if (append_ff) begin
            valid_in = 1'b1;
            byte_in  = answer_byte(idx_ff, ttl_ff, addr_ff);
            end_in   = (idx_ff == {ANS_IDX_W{1'b1}});
            send_in  = end_in && verdict_ff;
            idx_in   = idx_ff + ANS_IDX_W'(1);
            if (end_in) append_in = 1'b0;
         end else if (req_fire) begin
            valid_in = 1'b1;
            byte_in  = parse_res.echo_byte;
            end_in   = 1'b0;
            send_in  = 1'b0;
            if (req_frame_end) begin
               append_in  = 1'b1;
               idx_in     = '0;
               verdict_in = parse_res.send_ok;
            end
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         append_ff <= 1'b0;
         idx_ff    <= '0;
         addr_ff   <= ADDRESS_RESET;
         ttl_ff    <= TTL_RESET;
      end else begin
         valid_ff  <= valid_in;
         append_ff <= append_in;
         idx_ff    <= idx_in;
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_ANSWER_ADDRESS: addr_ff <= csr_wdata;
               CSR_ANSWER_TTL:     ttl_ff  <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      byte_ff    <= byte_in;
      end_ff     <= end_in;
      send_ff    <= send_in;
      verdict_ff <= verdict_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_out_end    = valid_ff && end_ff;
   assign rsp_send_frame = valid_ff && send_ff;

   `DNSR_ASSERT_ALWAYS(a_no_req_while_append, append_ff |-> !req_ready, "req_ready during answer append")
   `DNSR_ASSERT(a_append_starts_on_last, $rose(append_ff) |-> $past(req_fire_last), "append without last query byte")
   `DNSR_ASSERT(a_end_closes_append, (rsp_valid && rsp_out_end) |-> !append_ff, "frame end while answer still pending")
   `DNSR_ASSERT_ALWAYS(a_send_only_at_end, rsp_send_frame |-> rsp_out_end, "send verdict away from frame end")

endmodule

/* tb/sv/dns_a_query_fixed_responder_core_tb.sv */
// self-checking testbench for the dns a-query responder core
module dns_a_query_fixed_responder_core_tb;
   import dnsr_pkg::*;

   localparam int STALL_LIMIT = 5000;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_end;
      logic       send_frame;
   } reply_byte_type;

   // tracks the parser state of the current query and the reply bytes still owed
   class dns_reply_scoreboard_type;
      logic [31:0]      answer_address;
      logic [31:0]      answer_ttl;
      logic [15:0]      pos;
      phase_type        phase;
      logic [7:0]       label_left;
      logic [8:0]       name_len;
      logic [31:0]      qwords;
      logic [2:0]       qcount;
      bit               reject;
      reply_byte_type   pending_replies[$];
      int               failures;

      function new();
         answer_address = ADDRESS_RESET;
         answer_ttl = TTL_RESET;
         failures = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         pos = '0;
         phase = PH_HEADER;
         label_left = '0;
         name_len = '0;
         qwords = '0;
         qcount = '0;
         reject = 1'b0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] value);
         case (idx)
            CSR_ANSWER_ADDRESS: answer_address = value;
            CSR_ANSWER_TTL:     answer_ttl = value;
            default: ;
         endcase
      endfunction

      function int outstanding();
         return pending_replies.size();
      endfunction

      function void take_query_byte(logic [7:0] b, logic last);
         logic [7:0]           echo;
         logic [8*ANS_LEN-1:0] record;
         bit                   send;
         echo = b;
         if (pos == POS_FLAGS_HI) echo = RSP_FLAGS[15:8];
         else if (pos == POS_FLAGS_LO) echo = RSP_FLAGS[7:0];
         else if (pos == POS_ANCNT_HI) echo = RSP_ANCOUNT[15:8];
         else if (pos == POS_ANCNT_LO) echo = RSP_ANCOUNT[7:0];

         case (phase)
            PH_HEADER: begin
               if (pos == POS_FLAGS_HI && b[7]) reject = 1'b1;
               if (pos == POS_HDR_LAST) phase = PH_LABLEN;
            end
            PH_LABLEN: begin
               if (b == 8'h00) begin
                  phase = PH_QUEST;
               end else if (b[7:6] == 2'b11) begin
                  phase = PH_PTRLO;
               end else if (int'(name_len) + int'(b) + 1 >= NAME_LIMIT) begin
                  reject = 1'b1;
                  phase = PH_BAD;
               end else begin
                  name_len = name_len + b + 9'd1;
                  label_left = b;
                  phase = PH_LABEL;
               end
            end
            PH_LABEL: begin
               label_left = label_left - 8'd1;
               if (label_left == 8'd0) phase = PH_LABLEN;
            end
            PH_PTRLO: phase = PH_QUEST;
            PH_QUEST: begin
               qwords = {qwords[23:0], b};
               qcount = qcount + 3'd1;
               if (qcount >= 3'd4) phase = PH_DONE;
            end
            default: ;
         endcase
         if (pos != 16'hFFFF) pos = pos + 16'd1;

         pending_replies.push_back('{echo, 1'b0, 1'b0});
         if (!last) return;

         send = !reject && phase == PH_DONE && qwords == QUESTION_OK &&
                int'(pos) + ANS_LEN <= MAX_PACKET;
         record = {ANS_NAME_PTR, TYPE_A, CLASS_IN, answer_ttl, RDLEN_A, answer_address};
         for (int k = 0; k < ANS_LEN; k++)
            pending_replies.push_back('{record[8*(ANS_LEN-1-k) +: 8], k == ANS_LEN - 1,
                                        (k == ANS_LEN - 1) && send});
         clear_frame();
      endfunction

      function void check_reply_byte(logic [7:0] ob, logic oe, logic sf);
         reply_byte_type want;
         if (pending_replies.size() == 0) begin
            $error("reply byte %h arrived with nothing expected", ob);
            failures++;
            return;
         end
         want = pending_replies.pop_front();
         if (ob !== want.out_byte) begin
            $error("out_byte: expected %h, actual %h", want.out_byte, ob);
            failures++;
         end
         if (oe !== want.out_end) begin
            $error("out_end: expected %b, actual %b", want.out_end, oe);
            failures++;
         end
         if (sf !== want.send_frame) begin
            $error("send_frame: expected %b, actual %b", want.send_frame, sf);
            failures++;
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [7:0]           req_data_byte;
   logic                 req_frame_end;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [7:0]           rsp_out_byte;
   logic                 rsp_out_end;
   logic                 rsp_send_frame;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   dns_reply_scoreboard_type replies;
   logic [7:0]               query_bytes[$];
   int                       sender_idle;
   int                       receiver_idle;
   int                       stall_cycles;

   dns_a_query_fixed_responder_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_frame_end  (req_frame_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_out_end    (rsp_out_end),
      .rsp_send_frame (rsp_send_frame),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_idle);
   end

   // both channels are sampled in one process so a transaction is noted before its reply
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            replies.take_query_byte(req_data_byte, req_frame_end);
         if (rsp_valid && rsp_ready)
            replies.check_reply_byte(rsp_out_byte, rsp_out_end, rsp_send_frame);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles <= 0;
         end else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   function automatic void add_random(int count);
      for (int i = 0; i < count; i++) query_bytes.push_back(8'($urandom_range(255)));
   endfunction

   function automatic void add_header(bit qr);
      logic [7:0] h;
      for (int i = 0; i < 12; i++) begin
         h = 8'($urandom_range(255));
         if (i == 2) h[7] = qr;
         query_bytes.push_back(h);
      end
   endfunction

   function automatic void add_label(int len);
      query_bytes.push_back(8'(len));
      add_random(len);
   endfunction

   function automatic void add_name(bit use_ptr, int labels, int min_len, int max_len);
      for (int i = 0; i < labels; i++) add_label($urandom_range(max_len, min_len));
      if (use_ptr) begin
         query_bytes.push_back({2'b11, 6'($urandom_range(63))});
         query_bytes.push_back(8'($urandom_range(255)));
      end else begin
         query_bytes.push_back(8'h00);
      end
   endfunction

   function automatic void add_question(logic [15:0] qtype, logic [15:0] qclass);
      query_bytes.push_back(qtype[15:8]);
      query_bytes.push_back(qtype[7:0]);
      query_bytes.push_back(qclass[15:8]);
      query_bytes.push_back(qclass[7:0]);
   endfunction

   // mostly well-formed queries; the rest break one rule each or are random bytes
   function automatic void build_random_query();
      int          kind;
      int          cut;
      logic [15:0] qtype;
      logic [15:0] qclass;
      kind = $urandom_range(99);
      query_bytes.delete();
      if (kind >= 95) begin
         add_random($urandom_range(20, 1));
         return;
      end
      add_header(kind >= 60 && kind < 70);
      if (kind >= 90) add_name($urandom_range(1) == 1, 1, 8'h40, 8'h50);
      else add_name($urandom_range(3) == 0, $urandom_range(3), 1, 8);
      if (kind >= 70 && kind < 80) begin
         qtype = 16'($urandom_range(16'hFFFF));
         qclass = 16'($urandom_range(16'hFFFF));
         if ($urandom_range(1) == 1) qtype = TYPE_A;
         else qclass = CLASS_IN;
         add_question(qtype, qclass);
      end else begin
         add_question(TYPE_A, CLASS_IN);
      end
      if ($urandom_range(3) == 0) add_random($urandom_range(4, 1));
      if (kind >= 80 && kind < 90) begin
         cut = $urandom_range(query_bytes.size() - 1, 1);
         while (query_bytes.size() > cut) void'(query_bytes.pop_back());
      end
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic last);
      if ($urandom_range(99) < sender_idle) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_frame_end <= last;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_query();
      for (int i = 0; i < query_bytes.size(); i++)
         send_byte(query_bytes[i], i == query_bytes.size() - 1);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (replies.outstanding() != 0) @(posedge clock);
   endtask

   task automatic load_answer(input logic [CSR_W-1:0] address, input logic [CSR_W-1:0] ttl);
      csr_write_en <= 1'b1;
      csr_index <= CSR_ANSWER_ADDRESS;
      csr_wdata <= address;
      @(posedge clock);
      replies.set_register(CSR_ANSWER_ADDRESS, address);
      csr_index <= CSR_ANSWER_TTL;
      csr_wdata <= ttl;
      @(posedge clock);
      replies.set_register(CSR_ANSWER_TTL, ttl);
      csr_write_en <= 1'b0;
   endtask

   task automatic run_random(input int budget);
      int sent;
      sent = 0;
      while (sent < budget) begin
         build_random_query();
         sent += query_bytes.size();
         send_query();
         if ($urandom_range(7) == 0) wait_drained();
      end
      wait_drained();
   endtask

   initial begin
      replies = new();
      stall_cycles = 0;
      sender_idle = 6;
      receiver_idle = 67;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data_byte <= 8'h00;
      req_frame_end <= 1'b0;
      rsp_ready <= 1'b0;
      csr_write_en <= 1'b0;
      csr_index <= CSR_ANSWER_ADDRESS;
      csr_wdata <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // one-byte frame, then a minimal query with a pointer name and every flag bit but qr set
      query_bytes = '{8'hFF};
      send_query();
      query_bytes = '{8'h00, 8'h00, 8'h7F, 8'hFF, 8'h00, 8'h01, 8'hFF, 8'hFF,
                      8'h00, 8'h00, 8'h00, 8'h00, 8'hC0, 8'h0C,
                      8'h00, 8'h01, 8'h00, 8'h01};
      send_query();
      // header cut short with qr set
      query_bytes = '{8'hFF, 8'hFF, 8'h80, 8'h00, 8'h00};
      send_query();
      run_random(50);

      load_answer('0, '1);
      sender_idle = 67;
      receiver_idle = 6;
      // second label brings the dotted length exactly to the limit
      query_bytes.delete();
      add_header(1'b0);
      add_label(8'hBF);
      add_label(NAME_LIMIT - 193);
      query_bytes.push_back(8'h00);
      add_question(TYPE_A, CLASS_IN);
      send_query();
      run_random(40);

      load_answer('1, '0);
      sender_idle = 0;
      receiver_idle = 0;
      run_random(30);

      load_answer(32'($urandom), 32'($urandom));
      run_random(15);

      repeat (20) @(posedge clock);
      if (replies.failures == 0 && replies.outstanding() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+src
src/dnsr_pkg.sv
src/dnsr_parse.sv
src/dns_a_query_fixed_responder_core.sv
tb/sv/dns_a_query_fixed_responder_core_tb.sv
